FILE: rtl/bloom_filter_insert_query_top_macros.svh
// Assertion helpers used by the checked controller module.
`ifndef BLOOM_FILTER_INSERT_QUERY_TOP_MACROS_SVH
`define BLOOM_FILTER_INSERT_QUERY_TOP_MACROS_SVH

// Same-cycle implication, sampled on clk, off during reset.
`define BFQ_ASSERT_IMP(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// Next-cycle implication, sampled on clk, off during reset.
`define BFQ_ASSERT_NXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

FILE: rtl/bfq_pkg.sv
`timescale 1ns / 1ps
package bfq_pkg;

  localparam int MAX_FILTER_BITS_DEF = 8192;
  localparam int MAX_PROBES_DEF      = 30;

  localparam int HASH_W    = 32;
  localparam int HASH_ROT  = 17;
  localparam int BIT_CNT_W = 5;
  localparam int ROW_BITS  = 32;
  localparam int ROW_SEL_W = 5;
  localparam int MIN_BYTES = 8;

  localparam int HC_W      = 5;
  localparam int FB_W      = 11;
  localparam int CFG_IDX_W = 2;
  localparam int CFG_W     = 11;

  localparam logic [HC_W-1:0] HC_RESET = 5'd6;
  localparam logic [FB_W-1:0] FB_RESET = 11'd1024;

  localparam logic [CFG_IDX_W-1:0] REG_HASH_COUNT   = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_FILTER_BYTES = 2'd1;

  localparam logic [1:0] MODE_CLEAR  = 2'd0;
  localparam logic [1:0] MODE_INSERT = 2'd1;
  localparam logic [1:0] MODE_QUERY  = 2'd2;

  typedef enum logic [2:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_MOD,
    ST_READ,
    ST_CHECK,
    ST_FIN
  } state_t;

  typedef struct packed {
    logic hash_upd;
    logic start_key;
    logic clr_init;
    logic clr_step;
    logic mod_step;
    logic rd;
    logic check;
    logic load_out;
  } ctl_cmd_t;

  typedef struct packed {
    logic bit_last;
    logic probe_last;
    logic clr_done;
  } dp_status_t;

endpackage

FILE: rtl/bfq_ram.sv
`timescale 1ns / 1ps
module bfq_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 256,
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic             re,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

FILE: rtl/bfq_datapath.sv
`timescale 1ns / 1ps
module bfq_datapath #(
  parameter int MAX_FILTER_BITS = bfq_pkg::MAX_FILTER_BITS_DEF,
  parameter int MAX_PROBES      = bfq_pkg::MAX_PROBES_DEF
) (
  input  logic                           clk,
  input  logic                           rst,
  input  bfq_pkg::ctl_cmd_t              cmd,
  output bfq_pkg::dp_status_t            st,
  input  logic [1:0]                     mode,
  input  logic [7:0]                     key_byte,
  input  logic                           has_byte,
  input  logic                           cfg_we,
  input  logic [bfq_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [bfq_pkg::CFG_W-1:0]      cfg_data,
  output logic                           may_match,
  output logic [1:0]                     op_kind
);
  import bfq_pkg::*;

  localparam int BITS_W = $clog2(MAX_FILTER_BITS + 1);
  localparam int ROWS   = (MAX_FILTER_BITS + ROW_BITS - 1) / ROW_BITS;
  localparam int ROW_W  = (ROWS > 1) ? $clog2(ROWS) : 1;
  localparam int PRB_W  = $clog2(MAX_PROBES + 1);
  localparam int CW     = (BITS_W > FB_W + 3) ? BITS_W : FB_W + 3;
  localparam int CAP    = MAX_FILTER_BITS / 8;

  logic [HC_W-1:0]      hash_count;
  logic [FB_W-1:0]      filter_bytes;
  logic [HASH_W-1:0]    hash;
  logic [HASH_W-1:0]    ph;
  logic [HASH_W-1:0]    delta;
  logic [BITS_W-1:0]    rem;
  logic [BIT_CNT_W-1:0] bit_idx;
  logic [PRB_W-1:0]     probe_cnt;
  logic                 hit;
  logic [1:0]           op_mode;
  logic [ROW_W-1:0]     clr_addr;

  logic [HASH_W-1:0]    hash_next;
  logic [HC_W-1:0]      k_sat;
  logic [CW-1:0]        fb_sat;
  logic [BITS_W-1:0]    bits_eff;
  logic [BITS_W:0]      rem_sh;
  logic [BITS_W-1:0]    rem_next;
  logic [ROW_W-1:0]     row_addr;
  logic [ROW_SEL_W-1:0] bit_sel;
  logic                 ram_we;
  logic [ROW_W-1:0]     ram_waddr;
  logic [ROW_BITS-1:0]  ram_wdata;
  logic [ROW_BITS-1:0]  ram_rdata;

  // h*31 + byte as a shift and subtract; hash held when no byte is present
  always_comb begin
    if (has_byte) begin
      hash_next = (hash << 5) - hash + {{(HASH_W-8){1'b0}}, key_byte};
    end else begin
      hash_next = hash;
    end
  end

  always_comb begin
    if (hash_count == '0) begin
      k_sat = HC_W'(1);
    end else if (hash_count > HC_W'(MAX_PROBES)) begin
      k_sat = HC_W'(MAX_PROBES);
    end else begin
      k_sat = hash_count;
    end
  end

  always_comb begin
    if (CW'(filter_bytes) < CW'(MIN_BYTES)) begin
      fb_sat = CW'(MIN_BYTES);
    end else if (CW'(filter_bytes) > CW'(CAP)) begin
      fb_sat = CW'(CAP);
    end else begin
      fb_sat = CW'(filter_bytes);
    end
    bits_eff = BITS_W'(fb_sat << 3);
  end

  // one restoring remainder step, hash bit taken MSB first
  always_comb begin
    rem_sh = {rem, ph[bit_idx]};
    if (rem_sh >= {1'b0, bits_eff}) begin
      rem_next = BITS_W'(rem_sh - {1'b0, bits_eff});
    end else begin
      rem_next = BITS_W'(rem_sh);
    end
  end

  assign row_addr = ROW_W'(rem >> ROW_SEL_W);
  assign bit_sel  = rem[ROW_SEL_W-1:0];

  assign st.bit_last   = (bit_idx == '0);
  assign st.probe_last = (HC_W'(probe_cnt) == k_sat - HC_W'(1));
  assign st.clr_done   = (clr_addr == ROW_W'(ROWS - 1));

  always_comb begin
    ram_we    = cmd.clr_step || (cmd.check && (op_mode == MODE_INSERT));
    ram_waddr = cmd.clr_step ? clr_addr : row_addr;
    if (cmd.clr_step) begin
      ram_wdata = '0;
    end else begin
      ram_wdata = ram_rdata | (ROW_BITS'(1) << bit_sel);
    end
  end

  bfq_ram #(
    .WIDTH (ROW_BITS),
    .DEPTH (ROWS)
  ) u_store (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .re    (cmd.rd),
    .raddr (row_addr),
    .rdata (ram_rdata)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      hash_count   <= HC_RESET;
      filter_bytes <= FB_RESET;
      hash         <= '0;
      clr_addr     <= '0;
      bit_idx      <= '1;
      probe_cnt    <= '0;
      op_mode      <= MODE_CLEAR;
    end else begin
      if (cfg_we) begin
        case (cfg_index)
          REG_HASH_COUNT:   hash_count   <= cfg_data[HC_W-1:0];
          REG_FILTER_BYTES: filter_bytes <= cfg_data[FB_W-1:0];
          default: ;
        endcase
      end
      if (cmd.clr_init) begin
        hash     <= '0;
        clr_addr <= '0;
        op_mode  <= MODE_CLEAR;
      end else if (cmd.start_key) begin
        hash    <= '0;
        op_mode <= mode;
      end else if (cmd.hash_upd) begin
        hash <= hash_next;
      end
      if (cmd.clr_step && !st.clr_done) begin
        clr_addr <= clr_addr + ROW_W'(1);
      end
      if (cmd.start_key || cmd.check) begin
        bit_idx <= '1;
      end else if (cmd.mod_step) begin
        bit_idx <= bit_idx - BIT_CNT_W'(1);
      end
      if (cmd.start_key) begin
        probe_cnt <= '0;
      end else if (cmd.check) begin
        probe_cnt <= probe_cnt + PRB_W'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.start_key) begin
      ph    <= hash_next;
      delta <= {hash_next[HASH_ROT-1:0], hash_next[HASH_W-1:HASH_ROT]};
      hit   <= 1'b1;
    end else if (cmd.check) begin
      ph  <= ph + delta;
      hit <= hit & ram_rdata[bit_sel];
    end
    if (cmd.start_key || cmd.check) begin
      rem <= '0;
    end else if (cmd.mod_step) begin
      rem <= rem_next;
    end
    if (cmd.load_out) begin
      may_match <= (op_mode == MODE_QUERY) & hit;
      op_kind   <= op_mode;
    end
  end

endmodule

FILE: rtl/bfq_controller.sv
`timescale 1ns / 1ps
`include "bloom_filter_insert_query_top_macros.svh"
module bfq_controller (
  input  logic                clk,
  input  logic                rst,
  input  logic                in_valid,
  output logic                in_ready,
  input  logic [1:0]          in_mode,
  input  logic                in_last,
  output logic                out_valid,
  input  logic                out_ready,
  output bfq_pkg::ctl_cmd_t   cmd,
  input  bfq_pkg::dp_status_t st
);
  import bfq_pkg::*;

  state_t state;
  state_t state_next;
  logic   report_clear;
  logic   accept;

  assign accept = in_valid && in_ready;

  always_comb begin
    state_next = state;
    case (state)
      ST_CLEAR: begin
        if (st.clr_done) begin
          state_next = report_clear ? ST_FIN : ST_IDLE;
        end
      end
      ST_IDLE: begin
        if (accept) begin
          if (in_mode == MODE_CLEAR) begin
            state_next = ST_CLEAR;
          end else if ((in_mode inside {MODE_INSERT, MODE_QUERY}) && in_last) begin
            state_next = ST_MOD;
          end
        end
      end
      ST_MOD: begin
        if (st.bit_last) begin
          state_next = ST_READ;
        end
      end
      ST_READ:  state_next = ST_CHECK;
      ST_CHECK: state_next = st.probe_last ? ST_FIN : ST_MOD;
      ST_FIN: begin
        if (!out_valid || out_ready) begin
          state_next = ST_IDLE;
        end
      end
      default: state_next = ST_IDLE;
    endcase
  end

  always_comb begin
    cmd      = '0;
    in_ready = 1'b0;
    case (state)
      ST_CLEAR: cmd.clr_step = 1'b1;
      ST_IDLE: begin
        in_ready = 1'b1;
        if (accept) begin
          if (in_mode == MODE_CLEAR) begin
            cmd.clr_init = 1'b1;
          end else if (in_mode inside {MODE_INSERT, MODE_QUERY}) begin
            cmd.hash_upd  = !in_last;
            cmd.start_key = in_last;
          end
        end
      end
      ST_MOD:   cmd.mod_step = 1'b1;
      ST_READ:  cmd.rd       = 1'b1;
      ST_CHECK: cmd.check    = 1'b1;
      ST_FIN:   cmd.load_out = !out_valid || out_ready;
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= ST_CLEAR;
      report_clear <= 1'b0;
      out_valid    <= 1'b0;
    end else begin
      state <= state_next;
      if (cmd.clr_init) begin
        report_clear <= 1'b1;
      end else if (state == ST_CLEAR && st.clr_done) begin
        report_clear <= 1'b0;
      end
      out_valid <= cmd.load_out || (out_valid && !out_ready);
    end
  end

  `BFQ_ASSERT_IMP(a_check_after_read, state == ST_CHECK, $past(state) == ST_READ, "check without read")
  `BFQ_ASSERT_IMP(a_load_slot_free, cmd.load_out, !out_valid || out_ready, "result overwritten")
  `BFQ_ASSERT_NXT(a_mod_holds, state == ST_MOD && !st.bit_last, state == ST_MOD, "remainder cut short")

endmodule

FILE: rtl/bloom_filter_insert_query_top.sv
`timescale 1ns / 1ps
// Non-last key byte: accepted and hashed; no result.
// Last key byte: per probe, a 32-step remainder unit, a store read and a check/write;
// then the result register is loaded once the output is free; probes = saturated hash_count.
// Clear request: zeroes all ceil(MAX_FILTER_BITS/32) store rows, one per cycle, then result.
// Reset (synchronous, active high): same clearing pass, no request taken until it ends.
module bloom_filter_insert_query_top #(
  parameter int MAX_FILTER_BITS = bfq_pkg::MAX_FILTER_BITS_DEF,
  parameter int MAX_PROBES      = bfq_pkg::MAX_PROBES_DEF
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          s_tvalid,
  output logic                          s_tready,
  input  logic [15:0]                   s_tdata,   // key_byte[7:0], has_byte[8], zero pad
  input  logic [1:0]                    s_tuser,   // mode[1:0]
  input  logic                          s_tlast,
  output logic                          m_tvalid,
  input  logic                          m_tready,
  output logic [7:0]                    m_tdata,   // may_match[0], zero pad
  output logic [1:0]                    m_tuser,   // op_kind[1:0]
  input  logic                          cfg_valid,
  output logic                          cfg_ready,
  input  logic [bfq_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [bfq_pkg::CFG_W-1:0]     cfg_data
);
  import bfq_pkg::*;

  ctl_cmd_t   cmd;
  dp_status_t st;
  logic       may_match;

  assign cfg_ready = 1'b1;
  assign m_tdata   = {7'b0, may_match};

  bfq_controller u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (s_tvalid),
    .in_ready  (s_tready),
    .in_mode   (s_tuser),
    .in_last   (s_tlast),
    .out_valid (m_tvalid),
    .out_ready (m_tready),
    .cmd       (cmd),
    .st        (st)
  );

  bfq_datapath #(
    .MAX_FILTER_BITS (MAX_FILTER_BITS),
    .MAX_PROBES      (MAX_PROBES)
  ) u_dp (
    .clk       (clk),
    .rst       (rst),
    .cmd       (cmd),
    .st        (st),
    .mode      (s_tuser),
    .key_byte  (s_tdata[7:0]),
    .has_byte  (s_tdata[8]),
    .cfg_we    (cfg_valid && cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .may_match (may_match),
    .op_kind   (m_tuser)
  );

endmodule

FILE: verif/bloom_filter_insert_query_top_test.sv
`timescale 1ns / 1ps
module bloom_filter_insert_query_top_test;
  import bfq_pkg::*;

  localparam logic [1:0] MODE_IGNORED = 2'd3;
  localparam logic [CFG_IDX_W-1:0] REG_UNUSED = 2'd2;
  localparam int unsigned SIDE_STALL   = 128;
  localparam int unsigned KEY_CYCLES   = 2 + 34 * MAX_PROBES_DEF;
  localparam int unsigned CLEAR_CYCLES = MAX_FILTER_BITS_DEF / 32 + 2;
  localparam int unsigned TAIL_CYCLES  = KEY_CYCLES + 64;

  typedef struct packed {
    logic [1:0] mode;
    logic [7:0] key_byte;
    logic       has_byte;
    logic       last;
    logic       hold;      // wait for every outstanding result before sending
  } key_req_t;

  typedef struct packed {
    logic       may_match;
    logic [1:0] op_kind;
  } outcome_t;

  typedef struct packed {
    logic [95:0] bytes;
    logic [3:0]  len;
  } key_t;

  logic                 clk = 1'b0;
  logic                 rst = 1'b1;
  logic                 s_tvalid = 1'b0;
  logic                 s_tready;
  logic [15:0]          s_tdata = '0;  // key_byte[7:0], has_byte[8], zero pad
  logic [1:0]           s_tuser = '0;  // mode[1:0]
  logic                 s_tlast = 1'b0;
  logic                 m_tvalid;
  logic                 m_tready = 1'b0;
  logic [7:0]           m_tdata;       // may_match[0], zero pad
  logic [1:0]           m_tuser;       // op_kind[1:0]
  logic                 cfg_valid = 1'b0;
  logic                 cfg_ready;
  logic [CFG_IDX_W-1:0] cfg_index = '0;
  logic [CFG_W-1:0]     cfg_data = '0;

  key_req_t pending_reqs[$];
  outcome_t expected_outcomes[$];
  key_t     saved_keys[$];

  bit          filter_model [MAX_FILTER_BITS_DEF];
  logic [31:0] key_hash_model;
  logic [HC_W-1:0] probe_cfg;
  logic [FB_W-1:0] size_cfg;

  logic        results_drained = 1'b1;
  int unsigned send_idle_pct;
  int unsigned recv_idle_pct;
  int unsigned fail_count;
  int unsigned cycle_no;
  int unsigned work_bound = CLEAR_CYCLES + 1000;

  bloom_filter_insert_query_top dut (
    .clk       (clk),
    .rst       (rst),
    .s_tvalid  (s_tvalid),
    .s_tready  (s_tready),
    .s_tdata   (s_tdata),
    .s_tuser   (s_tuser),
    .s_tlast   (s_tlast),
    .m_tvalid  (m_tvalid),
    .m_tready  (m_tready),
    .m_tdata   (m_tdata),
    .m_tuser   (m_tuser),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  always #1 clk = ~clk;

  // Hash one request into the running key; on the last byte probe the store; a clear empties it.
  function automatic void predict_outcome(input logic [1:0] mode, input logic [7:0] kb,
                                          input logic hb, input logic lst);
    outcome_t    o;
    logic [31:0] h;
    logic [31:0] delta;
    int unsigned nbytes;
    int unsigned nprobes;
    int unsigned pos;
    logic        hit;
    if (mode == MODE_IGNORED) return;
    if (mode == MODE_CLEAR) begin
      foreach (filter_model[i]) filter_model[i] = 1'b0;
      key_hash_model = '0;
      o.may_match = 1'b0;
      o.op_kind = MODE_CLEAR;
      expected_outcomes = {expected_outcomes, o};
      return;
    end
    if (hb) key_hash_model = key_hash_model * 32'd31 + {24'd0, kb};
    if (!lst) return;
    h = key_hash_model;
    delta = (h >> HASH_ROT) | (h << (HASH_W - HASH_ROT));
    nbytes = size_cfg;
    if (nbytes < MIN_BYTES) nbytes = MIN_BYTES;
    if (nbytes > MAX_FILTER_BITS_DEF / 8) nbytes = MAX_FILTER_BITS_DEF / 8;
    nprobes = probe_cfg;
    if (nprobes < 1) nprobes = 1;
    if (nprobes > MAX_PROBES_DEF) nprobes = MAX_PROBES_DEF;
    hit = 1'b1;
    for (int j = 0; j < nprobes; j++) begin
      pos = h % (nbytes * 8);
      if (mode == MODE_INSERT) filter_model[pos] = 1'b1;
      else if (!filter_model[pos]) hit = 1'b0;
      h = h + delta;
    end
    key_hash_model = '0;
    o.may_match = (mode == MODE_QUERY) ? hit : 1'b0;
    o.op_kind = mode;
    expected_outcomes = {expected_outcomes, o};
  endfunction

  // Sender: present the next pending request once the current one is taken.
  always @(posedge clk) begin
    key_req_t r;
    if (rst) begin
      s_tvalid <= 1'b0;
    end else if (!s_tvalid || s_tready) begin
      if (pending_reqs.size() != 0 && $urandom_range(99) >= send_idle_pct &&
          (!pending_reqs[0].hold || (!s_tvalid && results_drained))) begin
        r = pending_reqs.pop_front();
        s_tvalid <= 1'b1;
        s_tdata  <= {7'd0, r.has_byte, r.key_byte};
        s_tuser  <= r.mode;
        s_tlast  <= r.last;
      end else begin
        s_tvalid <= 1'b0;
      end
    end
  end

  always @(posedge clk) begin
    if (rst) m_tready <= 1'b0;
    else m_tready <= ($urandom_range(99) >= recv_idle_pct);
  end

  // Watch all three channels; results are checked before the predictor moves on.
  always @(posedge clk) begin
    outcome_t want;
    if (!rst) begin
      if (m_tvalid && m_tready) begin
        if (expected_outcomes.size() == 0) begin
          $error("result with nothing expected: op_kind %0d, may_match %0d",
                 m_tuser, m_tdata[0]);
          fail_count++;
        end else begin
          want = expected_outcomes.pop_front();
          if (m_tdata[0] !== want.may_match) begin
            $error("may_match: expected %0d, got %0d", want.may_match, m_tdata[0]);
            fail_count++;
          end
          if (m_tuser !== want.op_kind) begin
            $error("op_kind: expected %0d, got %0d", want.op_kind, m_tuser);
            fail_count++;
          end
        end
      end
      if (cfg_valid && cfg_ready) begin
        if (cfg_index == REG_HASH_COUNT) probe_cfg = cfg_data[HC_W-1:0];
        else if (cfg_index == REG_FILTER_BYTES) size_cfg = cfg_data[FB_W-1:0];
      end
      if (s_tvalid && s_tready) predict_outcome(s_tuser, s_tdata[7:0], s_tdata[8], s_tlast);
    end
    results_drained <= (expected_outcomes.size() == 0);
  end

  always @(posedge clk) begin
    cycle_no++;
    if (cycle_no > 4 * work_bound + 20000) begin
      $display("CHECK FAILED");
      $finish;
    end
  end

  task automatic queue_req(input logic [1:0] mode, input logic [7:0] kb, input logic hb,
                           input logic lst, input logic hold);
    key_req_t r;
    r = '{mode: mode, key_byte: kb, has_byte: hb, last: lst, hold: hold};
    pending_reqs = {pending_reqs, r};
    if (mode == MODE_CLEAR) work_bound += CLEAR_CYCLES + 2 * SIDE_STALL;
    else if (lst && mode != MODE_IGNORED) work_bound += KEY_CYCLES + 2 * SIDE_STALL;
    else work_bound += SIDE_STALL + 2;
  endtask

  task automatic queue_key(input logic [1:0] op, input key_t k, input logic hold);
    logic [1:0] m;
    if (k.len == 0) queue_req(op, 8'($urandom_range(255)), 1'b0, 1'b1, hold);
    for (int i = 0; i < k.len; i++) begin
      m = op;
      // now and then an earlier byte comes under the other mode; the last one decides
      if (i + 1 < k.len && $urandom_range(9) == 0)
        m = (op == MODE_INSERT) ? MODE_QUERY : MODE_INSERT;
      queue_req(m, k.bytes[i*8 +: 8], 1'b1, i + 1 == k.len, hold && i == 0);
    end
  endtask

  task automatic queue_random(input int unsigned n);
    int unsigned done_cnt;
    int unsigned roll;
    logic [1:0]  op;
    key_t        k;
    done_cnt = 0;
    while (done_cnt < n) begin
      roll = $urandom_range(99);
      if (roll < 85) begin
        op = $urandom_range(1) ? MODE_QUERY : MODE_INSERT;
        if (op == MODE_QUERY && saved_keys.size() != 0 && $urandom_range(1)) begin
          k = saved_keys[$urandom_range(saved_keys.size() - 1)];
        end else begin
          k.len = ($urandom_range(9) == 0) ? 4'($urandom_range(12)) : 4'($urandom_range(4));
          k.bytes = {$urandom, $urandom, $urandom};
        end
        if (op == MODE_INSERT) begin
          saved_keys = {saved_keys, k};
          if (saved_keys.size() > 40) void'(saved_keys.pop_front());
        end
        queue_key(op, k, $urandom_range(99) == 0);
        done_cnt += (k.len == 0) ? 1 : k.len;
      end else if (roll < 91) begin
        queue_req(MODE_IGNORED, 8'($urandom_range(255)), 1'($urandom_range(1)),
                  1'($urandom_range(1)), 1'b0);
      end else if (roll < 94) begin
        queue_req(MODE_CLEAR, 8'($urandom_range(255)), 1'($urandom_range(1)),
                  1'($urandom_range(1)), 1'b0);
        done_cnt++;
      end else begin
        // stray byte: runs into the next key or is dropped by a clear
        queue_req($urandom_range(1) ? MODE_QUERY : MODE_INSERT, 8'($urandom_range(255)),
                  1'($urandom_range(1)), 1'b0, 1'b0);
        done_cnt++;
      end
    end
  endtask

  task automatic wait_idle();
    do @(negedge clk);
    while (!(pending_reqs.size() == 0 && !s_tvalid && results_drained));
    repeat (4) @(negedge clk);
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_W-1:0] val);
    work_bound += 50;
    @(posedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    do @(posedge clk);
    while (!cfg_ready);
    cfg_valid <= 1'b0;
  endtask

  task automatic set_idling(input int unsigned send_pct, input int unsigned recv_pct);
    send_idle_pct = send_pct;
    recv_idle_pct = recv_pct;
  endtask

  initial begin
    foreach (filter_model[i]) filter_model[i] = 1'b0;
    key_hash_model = '0;
    probe_cfg = HC_RESET;
    size_cfg = FB_RESET;
    set_idling(36, 68);
    repeat (2) @(posedge clk);
    rst <= 1'b0;
    @(negedge clk);

    queue_req(MODE_QUERY,   8'h00, 1'b0, 1'b1, 1'b0);  // empty key, empty store: miss
    queue_req(MODE_INSERT,  8'hFF, 1'b0, 1'b1, 1'b0);  // empty key insert
    queue_req(MODE_QUERY,   8'h3C, 1'b0, 1'b1, 1'b0);
    queue_req(MODE_INSERT,  8'h00, 1'b1, 1'b0, 1'b0);
    queue_req(MODE_INSERT,  8'hFF, 1'b1, 1'b1, 1'b0);
    queue_req(MODE_QUERY,   8'h00, 1'b1, 1'b0, 1'b0);
    queue_req(MODE_QUERY,   8'hFF, 1'b1, 1'b1, 1'b0);
    queue_req(MODE_QUERY,   8'hFF, 1'b1, 1'b0, 1'b0);  // mixed modes: last byte inserts
    queue_req(MODE_INSERT,  8'h80, 1'b1, 1'b1, 1'b0);
    queue_req(MODE_INSERT,  8'hFF, 1'b1, 1'b0, 1'b0);
    queue_req(MODE_QUERY,   8'h80, 1'b1, 1'b1, 1'b1);
    queue_req(MODE_IGNORED, 8'hAA, 1'b1, 1'b1, 1'b0);
    queue_req(MODE_IGNORED, 8'h55, 1'b0, 1'b0, 1'b0);
    queue_req(MODE_INSERT,  8'hA5, 1'b0, 1'b0, 1'b0);  // absent byte inside a key
    queue_req(MODE_INSERT,  8'h5A, 1'b1, 1'b1, 1'b0);
    queue_req(MODE_QUERY,   8'h5A, 1'b1, 1'b1, 1'b0);
    queue_req(MODE_INSERT,  8'h12, 1'b1, 1'b0, 1'b0);
    queue_req(MODE_CLEAR,   8'hFF, 1'b1, 1'b1, 1'b0);  // aborts the key in progress
    queue_req(MODE_QUERY,   8'h5A, 1'b1, 1'b1, 1'b0);
    queue_req(MODE_CLEAR,   8'h00, 1'b0, 1'b0, 1'b0);
    queue_req(MODE_QUERY,   8'h00, 1'b0, 1'b1, 1'b0);
    queue_random(430);

    wait_idle();
    write_reg(REG_HASH_COUNT, 11'd1);
    write_reg(REG_FILTER_BYTES, 11'd8);
    @(negedge clk);
    queue_random(300);

    wait_idle();
    set_idling(68, 36);
    write_reg(REG_HASH_COUNT, 11'd31);  // saturates to the probe maximum
    write_reg(REG_FILTER_BYTES, 11'd2047);
    @(negedge clk);
    queue_random(60);

    wait_idle();
    write_reg(REG_HASH_COUNT, 11'd0);
    write_reg(REG_FILTER_BYTES, 11'd0);
    write_reg(REG_UNUSED, 11'($urandom_range(2047)));  // unused index: no effect
    @(negedge clk);
    queue_random(250);

    for (int p = 0; p < 4; p++) begin
      wait_idle();
      if (p == 2) set_idling(0, 0);
      if (p == 1) write_reg(REG_HASH_COUNT, 11'($urandom_range(2047)));
      else write_reg(REG_HASH_COUNT, 11'($urandom_range(1, 10)));
      write_reg(REG_FILTER_BYTES, (p == 3) ? 11'd1023 : 11'($urandom_range(8, 1024)));
      @(negedge clk);
      queue_random(180);
    end

    wait_idle();
    repeat (TAIL_CYCLES) @(negedge clk);
    if (fail_count == 0 && expected_outcomes.size() == 0) begin
      $display("CHECK OK");
    end else begin
      if (expected_outcomes.size() != 0)
        $error("%0d expected results never arrived", expected_outcomes.size());
      $display("CHECK FAILED");
    end
    $finish;
  end

endmodule
